### sv/csw_pkg.sv
// ============================================================================
// csw_pkg
// Shared types, codes and the microprogram of the semaphore sequencer.
// ============================================================================
`default_nettype none

package csw_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF     = 16;

    localparam int OPCODE_W = 3;
    localparam int INIT_W   = 15;
    localparam int STATUS_W = 3;

    // opcodes; 5..7 mean nothing and fall to the default arm
    typedef enum logic [OPCODE_W-1:0] {
        OP_OPEN    = 3'd0,
        OP_WAIT    = 3'd1,
        OP_SIGNAL  = 3'd2,
        OP_TRYWAIT = 3'd3,
        OP_CLOSE   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_OPEN   = 3'd1,
        ST_BUSY       = 3'd2,
        ST_QUEUE_FULL = 3'd3,
        ST_COUNT_OVF  = 3'd4
    } t_status;

    // dispatch class of an incoming word
    typedef enum logic [3:0] {
        CLS_OPEN,
        CLS_NOP,
        CLS_NOT_OPEN,
        CLS_OVF,
        CLS_FULL,
        CLS_DEC,
        CLS_ENQ,
        CLS_BUSY,
        CLS_INC,
        CLS_SREL,
        CLS_CLOSE_EMPTY,
        CLS_DRAIN
    } t_cls;

    // datapath action
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_OPEN,
        ACT_DEC,
        ACT_ENQ,
        ACT_INC,
        ACT_INC_DEQ,
        ACT_CLOSE,
        ACT_CLOSE_DEQ
    } t_act;

    typedef enum logic [1:0] {
        JMP_DISPATCH,
        JMP_GOTO,
        JMP_UNTIL_LAST
    } t_jmp;

    // microprogram addresses
    typedef logic [3:0] t_upc;
    localparam t_upc U_IDLE        = 4'd0;
    localparam t_upc U_OPEN        = 4'd1;
    localparam t_upc U_NOP         = 4'd2;
    localparam t_upc U_NOT_OPEN    = 4'd3;
    localparam t_upc U_OVF         = 4'd4;
    localparam t_upc U_FULL        = 4'd5;
    localparam t_upc U_BUSY        = 4'd6;
    localparam t_upc U_DEC         = 4'd7;
    localparam t_upc U_ENQ         = 4'd8;
    localparam t_upc U_INC         = 4'd9;
    localparam t_upc U_SREL        = 4'd10;
    localparam t_upc U_CLOSE_EMPTY = 4'd11;
    localparam t_upc U_DRAIN       = 4'd12;

    typedef struct packed {
        t_act    act;
        logic    emit;
        t_status status;
        logic    blocks;
        logic    rvalid;
        logic    last_on_one;
        t_jmp    jmp;
        t_upc    target;
    } t_uword;

    typedef struct packed {
        t_cls cls;
        logic total_one;
    } t_dp_stat;

    // control store
    function automatic t_uword urom(input t_upc upc);
        t_uword w;
        w.act         = ACT_NONE;
        w.emit        = 1'b1;
        w.status      = ST_OK;
        w.blocks      = 1'b0;
        w.rvalid      = 1'b0;
        w.last_on_one = 1'b0;
        w.jmp         = JMP_GOTO;
        w.target      = U_IDLE;
        case (upc)
            U_IDLE: begin
                w.emit = 1'b0;
                w.jmp  = JMP_DISPATCH;
            end
            U_OPEN:        w.act = ACT_OPEN;
            U_NOP:         w.act = ACT_NONE;
            U_NOT_OPEN:    w.status = ST_NOT_OPEN;
            U_OVF:         w.status = ST_COUNT_OVF;
            U_FULL:        w.status = ST_QUEUE_FULL;
            U_BUSY:        w.status = ST_BUSY;
            U_DEC:         w.act = ACT_DEC;
            U_ENQ: begin
                w.act    = ACT_ENQ;
                w.blocks = 1'b1;
            end
            U_INC:         w.act = ACT_INC;
            U_SREL: begin
                w.act    = ACT_INC_DEQ;
                w.rvalid = 1'b1;
            end
            U_CLOSE_EMPTY: w.act = ACT_CLOSE;
            U_DRAIN: begin
                w.act         = ACT_CLOSE_DEQ;
                w.rvalid      = 1'b1;
                w.last_on_one = 1'b1;
                w.jmp         = JMP_UNTIL_LAST;
                w.target      = U_DRAIN;
            end
            default: begin
                w.emit = 1'b0;
            end
        endcase
        return w;
    endfunction

    // dispatch table: class -> routine entry
    function automatic t_upc entry_of(input t_cls cls);
        t_upc e;
        case (cls)
            CLS_OPEN:        e = U_OPEN;
            CLS_NOP:         e = U_NOP;
            CLS_NOT_OPEN:    e = U_NOT_OPEN;
            CLS_OVF:         e = U_OVF;
            CLS_FULL:        e = U_FULL;
            CLS_DEC:         e = U_DEC;
            CLS_ENQ:         e = U_ENQ;
            CLS_BUSY:        e = U_BUSY;
            CLS_INC:         e = U_INC;
            CLS_SREL:        e = U_SREL;
            CLS_CLOSE_EMPTY: e = U_CLOSE_EMPTY;
            CLS_DRAIN:       e = U_DRAIN;
            default:         e = U_NOP;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### sv/csw_useq.sv
// ============================================================================
// csw_useq
// Step counter and control store; jumps by dispatch class or drain count.
// ============================================================================
`default_nettype none

module csw_useq (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    input  wire                logic i_out_free,
    input  wire                csw_pkg::t_dp_stat i_stat,
    output csw_pkg::t_uword    o_uword,
    output logic               o_fire,
    output logic               o_in_ready
);

    csw_pkg::t_upc   r_upc;
    csw_pkg::t_upc   n_upc;
    csw_pkg::t_uword uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= csw_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_comb begin
        uw         = csw_pkg::urom(r_upc);
        // an emitting step waits for room in the output register
        o_fire     = !uw.emit || i_out_free;
        o_in_ready = (uw.jmp == csw_pkg::JMP_DISPATCH);
        n_upc      = r_upc;
        if (o_fire) begin
            case (uw.jmp)
                csw_pkg::JMP_DISPATCH: begin
                    if (i_in_valid) begin
                        n_upc = csw_pkg::entry_of(i_stat.cls);
                    end
                end
                csw_pkg::JMP_GOTO:       n_upc = uw.target;
                csw_pkg::JMP_UNTIL_LAST: n_upc = i_stat.total_one ? csw_pkg::U_IDLE
                                                                  : uw.target;
                default:                 n_upc = csw_pkg::U_IDLE;
            endcase
        end
        o_uword = uw;
    end

endmodule

`default_nettype wire

### sv/csw_dpath.sv
// ============================================================================
// csw_dpath
// Count, open flag, waiter ring and its pointers; classifies incoming words.
// ============================================================================
`default_nettype none

module csw_dpath #(
    parameter int QUEUE_DEPTH    = csw_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csw_pkg::THREAD_ID_BITS_DEF,
    parameter int COUNT_BITS     = csw_pkg::COUNT_BITS_DEF
) (
    input  wire               logic i_clk,
    input  wire               logic i_rst_n,
    input  wire               csw_pkg::t_uword i_uword,
    input  wire               logic i_fire,
    input  wire               logic i_accept,
    input  wire               logic [csw_pkg::OPCODE_W-1:0] i_opcode,
    input  wire               logic [THREAD_ID_BITS-1:0]    i_thread_id,
    input  wire               logic [csw_pkg::INIT_W-1:0]   i_init_value,
    output csw_pkg::t_dp_stat o_stat,
    output logic [COUNT_BITS-1:0]     o_next_count,
    output logic [THREAD_ID_BITS-1:0] o_rd_tid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [COUNT_BITS-1:0]     r_count, n_count;
    logic                      r_open, n_open;
    logic [PTR_W-1:0]          r_head, n_head;
    logic [PTR_W-1:0]          r_tail, n_tail;
    logic [TOT_W-1:0]          r_total, n_total;
    logic [THREAD_ID_BITS-1:0] r_tid;
    logic [csw_pkg::INIT_W-1:0] r_init;
    logic [THREAD_ID_BITS-1:0] r_ring [QUEUE_DEPTH];
    logic [THREAD_ID_BITS-1:0] r_rd_tid;

    logic                  at_min, at_max, neg, zero, full, empty, total_one;
    logic [PTR_W-1:0]      head_inc, tail_inc;
    logic [COUNT_BITS-1:0] init_sat;
    csw_pkg::t_cls         cls;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        at_min    = (r_count == CNT_MIN);
        at_max    = (r_count == CNT_MAX);
        neg       = r_count[COUNT_BITS-1];
        zero      = (r_count == '0);
        full      = (r_total == TOT_W'(QUEUE_DEPTH));
        empty     = (r_total == '0);
        total_one = (r_total == TOT_W'(1));
        head_inc  = ptr_inc(r_head);
        tail_inc  = ptr_inc(r_tail);
        init_sat  = (33'(r_init) > 33'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(r_init);

        // classify the word on the input port
        case (i_opcode)
            csw_pkg::OP_OPEN:    cls = csw_pkg::CLS_OPEN;
            csw_pkg::OP_WAIT:    cls = at_min ? csw_pkg::CLS_OVF :
                                       (neg || zero) ? (full ? csw_pkg::CLS_FULL
                                                             : csw_pkg::CLS_ENQ)
                                                     : csw_pkg::CLS_DEC;
            csw_pkg::OP_SIGNAL:  cls = at_max ? csw_pkg::CLS_OVF :
                                       (neg && !empty) ? csw_pkg::CLS_SREL
                                                       : csw_pkg::CLS_INC;
            csw_pkg::OP_TRYWAIT: cls = (!neg && !zero) ? csw_pkg::CLS_DEC
                                                       : csw_pkg::CLS_BUSY;
            csw_pkg::OP_CLOSE:   cls = empty ? csw_pkg::CLS_CLOSE_EMPTY
                                             : csw_pkg::CLS_DRAIN;
            default:             cls = csw_pkg::CLS_NOP;
        endcase
        if (!r_open && i_opcode != csw_pkg::OP_OPEN && cls != csw_pkg::CLS_NOP) begin
            cls = csw_pkg::CLS_NOT_OPEN;
        end

        n_count = r_count;
        n_open  = r_open;
        n_head  = r_head;
        n_tail  = r_tail;
        n_total = r_total;
        if (i_fire) begin
            case (i_uword.act)
                csw_pkg::ACT_OPEN: begin
                    n_count = init_sat;
                    n_open  = 1'b1;
                    n_head  = '0;
                    n_tail  = '0;
                    n_total = '0;
                end
                csw_pkg::ACT_DEC: n_count = r_count - COUNT_BITS'(1);
                csw_pkg::ACT_ENQ: begin
                    n_count = r_count - COUNT_BITS'(1);
                    n_tail  = tail_inc;
                    n_total = r_total + TOT_W'(1);
                end
                csw_pkg::ACT_INC: n_count = r_count + COUNT_BITS'(1);
                csw_pkg::ACT_INC_DEQ: begin
                    n_count = r_count + COUNT_BITS'(1);
                    n_head  = head_inc;
                    n_total = r_total - TOT_W'(1);
                end
                csw_pkg::ACT_CLOSE: begin
                    n_count = '0;
                    n_open  = 1'b0;
                    n_head  = '0;
                    n_tail  = '0;
                end
                csw_pkg::ACT_CLOSE_DEQ: begin
                    n_count = '0;
                    n_open  = 1'b0;
                    n_total = r_total - TOT_W'(1);
                    // pointers back to zero once the last waiter leaves
                    n_head  = total_one ? '0 : head_inc;
                    if (total_one) begin
                        n_tail = '0;
                    end
                end
                default: ;
            endcase
        end

        o_stat.cls       = cls;
        o_stat.total_one = total_one;
        o_next_count     = n_count;
        o_rd_tid         = r_rd_tid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_open  <= 1'b0;
            r_head  <= '0;
            r_tail  <= '0;
            r_total <= '0;
        end else begin
            r_count <= n_count;
            r_open  <= n_open;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_total <= n_total;
        end
    end

    // payload latch and ring; read port follows the next head
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tid  <= i_thread_id;
            r_init <= i_init_value;
        end
        if (i_fire && i_uword.act == csw_pkg::ACT_ENQ) begin
            r_ring[r_tail] <= r_tid;
        end
        r_rd_tid <= r_ring[n_head];
    end

endmodule

`default_nettype wire

### sv/counting_semaphore_wait_queue.sv
// ============================================================================
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO of blocked thread IDs, run by a microcoded
// sequencer over a small datapath, results held in an output register.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ------------------------------
//  in        input      i_in_valid / o_in_ready    opcode, thread_id, init_value
//  out       output     o_out_valid / i_out_ready  status, caller_blocks,
//                                                  released_valid, released_thread,
//                                                  count_after, last
//
//  Steps: an ordinary word passes the dispatch step that accepts it and
//  one execute step that updates state and loads the result word.
//  close with N queued waiters repeats the drain step once per waiter,
//  bounded by the single ring read port.
//  Stalls: an execute step holds while the output register is full and not
//  being taken; the next word is accepted while a result still waits.
//  Reset: i_rst_n (sync, active low) clears the step counter, count, open flag,
//  ring pointers and output valid; ring contents are not cleared.
//
`default_nettype none

module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH    = csw_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csw_pkg::THREAD_ID_BITS_DEF,
    parameter int COUNT_BITS     = csw_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input words
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [csw_pkg::OPCODE_W-1:0]    i_opcode,
    input  wire logic [THREAD_ID_BITS-1:0]       i_thread_id,
    input  wire logic [csw_pkg::INIT_W-1:0]      i_init_value,
    // result words
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [csw_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_caller_blocks,
    output logic                                 o_released_valid,
    output logic [THREAD_ID_BITS-1:0]            o_released_thread,
    output logic [COUNT_BITS-1:0]                o_count_after,
    output logic                                 o_last
);

    csw_pkg::t_uword   uword;
    csw_pkg::t_dp_stat stat;
    logic              fire;
    logic              in_ready;
    logic              out_free;
    logic              accept;
    logic              load;
    logic [COUNT_BITS-1:0]     next_count;
    logic [THREAD_ID_BITS-1:0] rd_tid;

    // output register
    logic                      r_out_valid;
    csw_pkg::t_status          r_status;
    logic                      r_blocks;
    logic                      r_rvalid;
    logic [THREAD_ID_BITS-1:0] r_rthread;
    logic [COUNT_BITS-1:0]     r_count_after;
    logic                      r_last;

    // room for a new result when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && in_ready;
    assign load     = fire && uword.emit;

    csw_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_uword    (uword),
        .o_fire     (fire),
        .o_in_ready (in_ready)
    );

    csw_dpath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uword      (uword),
        .i_fire       (fire),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_thread_id  (i_thread_id),
        .i_init_value (i_init_value),
        .o_stat       (stat),
        .o_next_count (next_count),
        .o_rd_tid     (rd_tid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; count is the post-operation value
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status      <= uword.status;
            r_blocks      <= uword.blocks;
            r_rvalid      <= uword.rvalid;
            r_rthread     <= uword.rvalid ? rd_tid : '0;
            r_count_after <= next_count;
            r_last        <= uword.last_on_one ? stat.total_one : 1'b1;
        end
    end

    assign o_in_ready        = in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_caller_blocks   = r_blocks;
    assign o_released_valid  = r_rvalid;
    assign o_released_thread = r_rthread;
    assign o_count_after     = r_count_after;
    assign o_last            = r_last;

endmodule

`default_nettype wire

### test/counting_semaphore_wait_queue_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// counting_semaphore_wait_queue_tb
// Drives open/wait/signal/trywait/close words into the semaphore under random
// idling on both channels, predicts every result word (including the
// per-waiter drain of close), and checks each field in order of arrival.
// ============================================================================

module counting_semaphore_wait_queue_tb;

    localparam int QDEPTH      = csw_pkg::QUEUE_DEPTH_DEF;
    localparam int RAND_ITEMS  = 420;
    localparam int CALM_TAIL   = 60;        // last random words run with no idling
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 20;

    localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] CNT_MIN = 16'sh8000;

    // one expected result word
    typedef struct packed {
        csw_pkg::t_status status;
        logic             blocks;
        logic             rvalid;
        logic [7:0]       rthread;
        logic [15:0]      count;
        logic             last;
    } t_sem_reply;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_opcode;
    logic [7:0]  i_thread_id;
    logic [14:0] i_init_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic        o_caller_blocks;
    logic        o_released_valid;
    logic [7:0]  o_released_thread;
    logic [15:0] o_count_after;
    logic        o_last;

    counting_semaphore_wait_queue DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_thread_id       (i_thread_id),
        .i_init_value      (i_init_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_caller_blocks   (o_caller_blocks),
        .o_released_valid  (o_released_valid),
        .o_released_thread (o_released_thread),
        .o_count_after     (o_count_after),
        .o_last            (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow semaphore state
    // ------------------------------------------------------------------------
    logic signed [15:0] sem_cnt;
    logic               sem_open;
    logic [7:0]         wait_ring [QDEPTH];
    logic [3:0]         ring_rd;
    logic [3:0]         ring_wr;
    logic [4:0]         waiters;

    t_sem_reply pending_replies[$];

    // bookkeeping
    int  fail_cnt    = 0;
    int  n_items     = 0;
    int  n_results   = 0;
    int  n_blocked   = 0;
    int  n_released  = 0;
    int  n_full      = 0;
    int  n_ovf       = 0;
    int  n_drains    = 0;
    int  cycle_cnt   = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;   // no idling on either side when set

    // Apply one accepted word to the shadow state and queue its result words.
    function automatic void apply_semaphore_op(logic [2:0] op, logic [7:0] tid,
                                               logic [14:0] init);
        t_sem_reply r;
        r.status  = csw_pkg::ST_OK;
        r.blocks  = 1'b0;
        r.rvalid  = 1'b0;
        r.rthread = '0;
        r.last    = 1'b1;
        if (op == csw_pkg::OP_OPEN) begin
            // a 15-bit init can never exceed the signed 16-bit max, so no clamp
            sem_cnt  = signed'({1'b0, init});
            sem_open = 1'b1;
            ring_rd  = '0;
            ring_wr  = '0;
            waiters  = '0;     // reopen drops queued waiters silently
        end else if (op > csw_pkg::OP_CLOSE) begin
            // undefined opcodes: no-op, report stored count
        end else if (!sem_open) begin
            r.status = csw_pkg::ST_NOT_OPEN;
        end else begin
            case (op)
                csw_pkg::OP_WAIT: begin
                    if (sem_cnt == CNT_MIN) begin
                        r.status = csw_pkg::ST_COUNT_OVF;
                        n_ovf++;
                    end else if (sem_cnt <= 0) begin
                        if (waiters >= QDEPTH) begin
                            r.status = csw_pkg::ST_QUEUE_FULL;
                            n_full++;
                        end else begin
                            sem_cnt            = sem_cnt - 16'sd1;
                            wait_ring[ring_wr] = tid;
                            ring_wr++;
                            waiters++;
                            r.blocks = 1'b1;
                            n_blocked++;
                        end
                    end else begin
                        sem_cnt = sem_cnt - 16'sd1;
                    end
                end
                csw_pkg::OP_SIGNAL: begin
                    if (sem_cnt == CNT_MAX) begin
                        r.status = csw_pkg::ST_COUNT_OVF;
                        n_ovf++;
                    end else begin
                        sem_cnt = sem_cnt + 16'sd1;
                        // still at or below zero: hand the slot to the oldest waiter
                        if (sem_cnt <= 0 && waiters > 0) begin
                            r.rvalid  = 1'b1;
                            r.rthread = wait_ring[ring_rd];
                            ring_rd++;
                            waiters--;
                            n_released++;
                        end
                    end
                end
                csw_pkg::OP_TRYWAIT: begin
                    if (sem_cnt > 0)
                        sem_cnt = sem_cnt - 16'sd1;
                    else
                        r.status = csw_pkg::ST_BUSY;
                end
                csw_pkg::OP_CLOSE: begin
                    sem_cnt  = '0;
                    sem_open = 1'b0;
                    if (waiters != 0) begin
                        // one word per waiter, oldest first, last on the final one
                        n_drains++;
                        while (waiters != 0) begin
                            r.rvalid  = 1'b1;
                            r.rthread = wait_ring[ring_rd];
                            ring_rd++;
                            waiters--;
                            r.count   = '0;
                            r.last    = (waiters == 0);
                            pending_replies.push_back(r);
                            n_released++;
                        end
                        ring_rd = '0;
                        ring_wr = '0;
                        return;
                    end
                    ring_rd = '0;
                    ring_wr = '0;
                end
                default: ;
            endcase
        end
        r.count = sem_cnt;
        pending_replies.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one word per call, entered and left on a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [2:0] op, input logic [7:0] tid,
                             input logic [14:0] init);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap        = $urandom_range(1, 11);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_thread_id  = tid;
        i_init_value = init;
        do @(posedge i_clk); while (!o_in_ready);
        apply_semaphore_op(op, tid, init);
        n_items++;
        @(negedge i_clk);
    endtask

    // random word for a well-formed session, weighted toward wait/signal
    function automatic logic [2:0] pick_session_op();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)      return csw_pkg::OP_WAIT;
        else if (p < 75) return csw_pkg::OP_SIGNAL;
        else if (p < 92) return csw_pkg::OP_TRYWAIT;
        else if (p < 97) return csw_pkg::OP_CLOSE;
        else             return csw_pkg::OP_OPEN;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, released in the calm tail
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (calm) begin
            stall_left  = 0;
            i_out_ready = 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_ready = 1'b0;
            stall_left  = $urandom_range(1, 11) - 1;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_sem_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_replies.size() == 0) begin
                fail_cnt++;
                $error("result word with nothing expected: status %0d count %0d",
                       o_status, $signed(o_count_after));
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) begin
                    fail_cnt++;
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                end
                if (o_caller_blocks !== want.blocks) begin
                    fail_cnt++;
                    $error("caller_blocks: expected %0d, actual %0d",
                           want.blocks, o_caller_blocks);
                end
                if (o_released_valid !== want.rvalid) begin
                    fail_cnt++;
                    $error("released_valid: expected %0d, actual %0d",
                           want.rvalid, o_released_valid);
                end
                if (o_released_thread !== want.rthread) begin
                    fail_cnt++;
                    $error("released_thread: expected 0x%02h, actual 0x%02h",
                           want.rthread, o_released_thread);
                end
                if (o_count_after !== want.count) begin
                    fail_cnt++;
                    $error("count_after: expected %0d, actual %0d",
                           $signed(want.count), $signed(o_count_after));
                end
                if (o_last !== want.last) begin
                    fail_cnt++;
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, pending_replies.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // everything but open is rejected before the first open; stray opcodes are no-ops
    task automatic test_closed_semaphore();
        send_word(csw_pkg::OP_WAIT,    8'h5A, 15'h7FFF);
        send_word(csw_pkg::OP_SIGNAL,  8'hA5, 15'h0000);
        send_word(csw_pkg::OP_TRYWAIT, 8'h00, 15'h2AAA);
        send_word(csw_pkg::OP_CLOSE,   8'hFF, 15'h5555);
        send_word(3'd7,                8'hC3, 15'h1234);
        send_word(3'd5,                8'h3C, 15'h4321);
    endtask

    // max count: signal overflows, trywait succeeds, trywait at zero is busy
    task automatic test_count_limits();
        send_word(csw_pkg::OP_OPEN,    8'h00, 15'h7FFF);
        send_word(csw_pkg::OP_SIGNAL,  8'h11, 15'h0000);
        send_word(csw_pkg::OP_TRYWAIT, 8'h22, 15'h0000);
        send_word(csw_pkg::OP_SIGNAL,  8'h33, 15'h0000);
        send_word(3'd6,                8'h44, 15'h0000);
        send_word(csw_pkg::OP_OPEN,    8'h00, 15'h0000);
        send_word(csw_pkg::OP_TRYWAIT, 8'h55, 15'h0000);
    endtask

    // waiters queue in order; signals release oldest first, then count goes positive
    task automatic test_block_and_release();
        send_word(csw_pkg::OP_WAIT,   8'hFF, 15'h0000);
        send_word(csw_pkg::OP_WAIT,   8'h00, 15'h0000);
        send_word(csw_pkg::OP_SIGNAL, 8'h12, 15'h0000);
        send_word(csw_pkg::OP_SIGNAL, 8'h34, 15'h0000);
        send_word(csw_pkg::OP_SIGNAL, 8'h56, 15'h0000);
        send_word(csw_pkg::OP_WAIT,   8'h78, 15'h0000);
    endtask

    // reopen drops waiters; close drains, then rejects; empty close gives one word
    task automatic test_reopen_and_close();
        send_word(csw_pkg::OP_WAIT,   8'h81, 15'h0000);
        send_word(csw_pkg::OP_OPEN,   8'h00, 15'h0001);
        send_word(csw_pkg::OP_SIGNAL, 8'h00, 15'h0000);
        send_word(csw_pkg::OP_WAIT,   8'h7E, 15'h0000);
        send_word(csw_pkg::OP_WAIT,   8'h7E, 15'h0000);
        send_word(csw_pkg::OP_WAIT,   8'h7E, 15'h0000);
        send_word(csw_pkg::OP_CLOSE,  8'h00, 15'h0000);
        send_word(csw_pkg::OP_CLOSE,  8'h00, 15'h0000);
        send_word(csw_pkg::OP_OPEN,   8'h00, 15'h0003);
        send_word(csw_pkg::OP_CLOSE,  8'h00, 15'h0000);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly well-formed sessions, some fill-to-full runs,
    // some near-max sessions, and raw noise including undefined opcodes
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int start;
        int pick;
        int len;
        start = n_items;
        while (n_items - start < RAND_ITEMS) begin
            calm = (n_items - start) >= (RAND_ITEMS - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // fill the wait queue near or past its depth, then drain with close
                send_word(csw_pkg::OP_OPEN, 8'($urandom_range(0, 255)),
                          15'($urandom_range(0, 2)));
                len = $urandom_range(16, 21);
                repeat (len)
                    send_word(csw_pkg::OP_WAIT, 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 32767)));
                repeat ($urandom_range(0, 3))
                    send_word(csw_pkg::OP_SIGNAL, 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 32767)));
                send_word(csw_pkg::OP_CLOSE, 8'($urandom_range(0, 255)),
                          15'($urandom_range(0, 32767)));
            end else if (pick < 65) begin
                // ordinary session, mostly on a small count
                if ($urandom_range(0, 9) == 0)
                    send_word(csw_pkg::OP_OPEN, 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 32767)));
                else
                    send_word(csw_pkg::OP_OPEN, 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 3)));
                len = $urandom_range(1, 24);
                repeat (len)
                    send_word(pick_session_op(), 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 32767)));
                if ($urandom_range(0, 9) < 7)
                    send_word(csw_pkg::OP_CLOSE, 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 32767)));
            end else if (pick < 75) begin
                // session at the top of the count range
                send_word(csw_pkg::OP_OPEN, 8'($urandom_range(0, 255)),
                          15'h7FFF - 15'($urandom_range(0, 2)));
                repeat ($urandom_range(1, 6))
                    send_word($urandom_range(0, 1) ? csw_pkg::OP_SIGNAL
                                                   : csw_pkg::OP_TRYWAIT,
                              8'($urandom_range(0, 255)), 15'($urandom_range(0, 32767)));
            end else begin
                // noise: any opcode, any fields
                send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          15'($urandom_range(0, 32767)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = csw_pkg::OP_OPEN;
        i_thread_id  = '0;
        i_init_value = '0;
        i_out_ready  = 1'b0;
        sem_cnt      = '0;
        sem_open     = 1'b0;
        ring_rd      = '0;
        ring_wr      = '0;
        waiters      = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_closed_semaphore();
        test_count_limits();
        test_block_and_release();
        test_reopen_and_close();
        test_random_traffic();

        i_in_valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d operations, %0d result words checked, %0d callers blocked",
                 n_items, n_results, n_blocked);
        $display("released %0d waiters over %0d draining closes; %0d full-queue, %0d overflow",
                 n_released, n_drains, n_full, n_ovf);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
